[hw/rtl/mqsr_pkg.sv]
`timescale 1ns / 1ps

package mqsr_pkg;

  localparam int NUM_BOXES   = 8;
  localparam int DEPTH       = 16;
  localparam int HANDLE_BITS = 16;

  // Field widths fixed by the interface.
  localparam int OP_W     = 2;
  localparam int BOXIN_W  = 3;
  localparam int SND_W    = 3;
  localparam int HDLIN_W  = 16;
  localparam int STAT_W   = 2;

  // Widths that follow from the sizes above.
  localparam int BOX_W  = (NUM_BOXES > 1) ? $clog2(NUM_BOXES) : 1;
  localparam int POS_W  = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int SLOTS  = NUM_BOXES * DEPTH;
  localparam int ADDR_W = $clog2(SLOTS);

  localparam logic [OP_W-1:0] OP_ENQ      = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ_ANY  = 2'd1;
  localparam logic [OP_W-1:0] OP_DEQ_FROM = 2'd2;

  localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
  localparam logic [STAT_W-1:0] ST_NONE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [SND_W-1:0]       sender;
    logic [HANDLE_BITS-1:0] handle;
  } slot_t;

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [BOX_W-1:0] b,
                                                  input logic [POS_W-1:0] p);
    slot_addr = ADDR_W'(b) * ADDR_W'(DEPTH) + ADDR_W'(p);
  endfunction

endpackage

[hw/rtl/mailbox_queue_selective_receive.sv]
`timescale 1ns / 1ps

// Mailbox store: one bounded FIFO of message handles per destination box.
// Input channel (in_valid/in_stall) carries one command beat: enqueue, dequeue
// the head, or dequeue the oldest entry from a given sender. Every command
// gives exactly one result beat on the output channel (out_valid/out_stall)
// with a status, the removed handle and sender, and whether the box is empty.
// Entries live in a single-port-write, single-port-read slot memory; each box
// owns DEPTH consecutive slots with its head in the first one.
// An enqueue writes the tail slot in S_ENQ unless the box is full, then moves
// to S_FIN. A dequeue walks the box one slot per cycle through the memory read
// port in S_WALK, and after a match the same walk writes each later entry one
// slot down. A new command is taken only once the previous one has reached the
// output register.
// The output register holds a result while out_stall is high; the next
// command may be accepted and worked on meanwhile, and waits before its own
// result is loaded. Reset clears the fill counts and the control state; the
// slot memory is not cleared, as it is only read below each fill count.
module mailbox_queue_selective_receive
  import mqsr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [OP_W-1:0]    in_opcode,
  input  logic [BOXIN_W-1:0] in_box,
  input  logic [SND_W-1:0]   in_msg_sender,
  input  logic [HDLIN_W-1:0] in_msg_handle,
  input  logic [SND_W-1:0]   in_want_sender,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [STAT_W-1:0]  out_status,
  output logic [HDLIN_W-1:0] out_got_handle,
  output logic [SND_W-1:0]   out_got_sender,
  output logic               out_now_empty
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ENQ  = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [FILL_W-1:0]      fill_r [NUM_BOXES];
  slot_t                  mem [SLOTS];
  slot_t                  rd_data_r;

  logic [OP_W-1:0]        op_r;
  logic [BOX_W-1:0]       box_r;
  logic [SND_W-1:0]       want_r;
  slot_t                  new_slot_r;
  logic [FILL_W-1:0]      n_r;
  logic [FILL_W-1:0]      rd_pos_r;
  logic [POS_W-1:0]       dpos_r;
  logic                   dvalid_r;
  logic                   found_r;
  logic [STAT_W-1:0]      res_status_r;
  logic [HANDLE_BITS-1:0] gh_r;
  logic [SND_W-1:0]       gs_r;

  logic [STAT_W-1:0]      out_status_r;
  logic [HDLIN_W-1:0]     out_got_handle_r;
  logic [SND_W-1:0]       out_got_sender_r;
  logic                   out_now_empty_r;
  logic                   out_valid_r;

  logic                   accept;
  logic [BOX_W-1:0]       box_sel;
  logic                   rd_en;
  logic                   match;
  logic                   walk_done;
  logic                   enq_ok;
  logic                   we;
  logic [ADDR_W-1:0]      waddr;
  slot_t                  wdata;
  logic                   out_free;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign box_sel  = BOX_W'(in_box % NUM_BOXES);

  assign rd_en     = (state_r == S_WALK) && (rd_pos_r < n_r);
  assign match     = (op_r == OP_DEQ_ANY) || (rd_data_r.sender == want_r);
  assign walk_done = (state_r == S_WALK) && !rd_en && !dvalid_r;
  assign enq_ok    = (n_r < FILL_W'(DEPTH));
  assign out_free  = !out_valid_r || !out_stall;

  // Either the enqueue write at the tail or one step of closing the gap.
  always_comb begin
    we    = 1'b0;
    waddr = slot_addr(box_r, n_r[POS_W-1:0]);
    wdata = new_slot_r;
    if (state_r == S_ENQ) begin
      we = enq_ok;
    end else if (state_r == S_WALK && dvalid_r && found_r) begin
      we    = 1'b1;
      waddr = slot_addr(box_r, dpos_r - POS_W'(1));
      wdata = rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem[slot_addr(box_r, rd_pos_r[POS_W-1:0])];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_opcode == OP_ENQ) begin
            state_nxt = S_ENQ;
          end else if (in_opcode == OP_DEQ_ANY || in_opcode == OP_DEQ_FROM) begin
            state_nxt = S_WALK;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_ENQ:   state_nxt = S_FIN;
      S_WALK:  if (walk_done) state_nxt = S_FIN;
      S_FIN:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      dvalid_r    <= 1'b0;
      for (int i = 0; i < NUM_BOXES; i++) begin
        fill_r[i] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      dvalid_r <= rd_en;
      if (state_r == S_ENQ && enq_ok) begin
        fill_r[box_r] <= n_r + FILL_W'(1);
      end else if (walk_done && found_r) begin
        fill_r[box_r] <= n_r - FILL_W'(1);
      end
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r              <= in_opcode;
      box_r             <= box_sel;
      want_r            <= in_want_sender;
      new_slot_r.sender <= in_msg_sender;
      new_slot_r.handle <= in_msg_handle[HANDLE_BITS-1:0];
      n_r               <= fill_r[box_sel];
      rd_pos_r          <= '0;
      found_r           <= 1'b0;
      res_status_r      <= ST_NONE;
      gh_r              <= '0;
      gs_r              <= '0;
    end
    if (state_r == S_ENQ) begin
      res_status_r <= enq_ok ? ST_DONE : ST_FULL;
    end
    if (rd_en) begin
      rd_pos_r <= rd_pos_r + FILL_W'(1);
      dpos_r   <= rd_pos_r[POS_W-1:0];
    end
    // The first match is taken out; every later entry then moves down a slot.
    if (state_r == S_WALK && dvalid_r && !found_r && match) begin
      found_r <= 1'b1;
      gh_r    <= rd_data_r.handle;
      gs_r    <= rd_data_r.sender;
    end
    if (walk_done && found_r) begin
      res_status_r <= ST_DONE;
    end
    if (state_r == S_FIN && out_free) begin
      out_status_r     <= res_status_r;
      out_got_handle_r <= HDLIN_W'(gh_r);
      out_got_sender_r <= gs_r;
      out_now_empty_r  <= (fill_r[box_r] == '0);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_got_handle = out_got_handle_r;
  assign out_got_sender = out_got_sender_r;
  assign out_now_empty  = out_now_empty_r;

endmodule

[sim/tb_mailbox_queue_selective_receive.sv]
`timescale 1ns / 1ps

module tb_mailbox_queue_selective_receive;
  import mqsr_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int N_ROWS      = 14;
  localparam int N_RANDOM    = 800;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT  = 4000;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [BOXIN_W-1:0] box;
    logic [SND_W-1:0]   msg_sender;
    logic [HDLIN_W-1:0] msg_handle;
    logic [SND_W-1:0]   want_sender;
  } mail_cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [HDLIN_W-1:0] got_handle;
    logic [SND_W-1:0]   got_sender;
    logic               now_empty;
  } mail_res_t;

  typedef struct {
    mail_cmd_t cmd;
    int        reps;
    bit        typed;
    mail_res_t res;
  } dir_row_t;

  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               in_valid       = 1'b0;
  logic               in_stall;
  logic [OP_W-1:0]    in_opcode      = '0;
  logic [BOXIN_W-1:0] in_box         = '0;
  logic [SND_W-1:0]   in_msg_sender  = '0;
  logic [HDLIN_W-1:0] in_msg_handle  = '0;
  logic [SND_W-1:0]   in_want_sender = '0;
  logic               out_valid;
  logic               out_stall      = 1'b0;
  logic [STAT_W-1:0]  out_status;
  logic [HDLIN_W-1:0] out_got_handle;
  logic [SND_W-1:0]   out_got_sender;
  logic               out_now_empty;

  // Mirror of the mailbox store.
  logic [HANDLE_BITS-1:0] mirror_handle [NUM_BOXES][DEPTH];
  logic [SND_W-1:0]       mirror_sender [NUM_BOXES][DEPTH];
  int unsigned            mirror_fill   [NUM_BOXES];

  mail_res_t  pending_results [$];
  int         mismatches    = 0;
  int         burst_left    = 0;
  int         idle_cycles   = 0;
  bit         hold_request  = 1'b0;
  dir_row_t   directed_rows [N_ROWS];

  always #2 clk = ~clk;

  mailbox_queue_selective_receive DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_box        (in_box),
    .in_msg_sender (in_msg_sender),
    .in_msg_handle (in_msg_handle),
    .in_want_sender(in_want_sender),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_got_handle(out_got_handle),
    .out_got_sender(out_got_sender),
    .out_now_empty (out_now_empty)
  );

  // Takes entry pos out of box b and closes the gap behind it.
  function automatic void take_entry(int b, int pos, inout mail_res_t r);
    r.status     = ST_DONE;
    r.got_handle = HDLIN_W'(mirror_handle[b][pos]);
    r.got_sender = mirror_sender[b][pos];
    for (int i = pos; i + 1 < int'(mirror_fill[b]); i++) begin
      mirror_handle[b][i] = mirror_handle[b][i+1];
      mirror_sender[b][i] = mirror_sender[b][i+1];
    end
    mirror_fill[b] = mirror_fill[b] - 1;
  endfunction

  function automatic mail_res_t mailbox_step(mail_cmd_t c);
    mail_res_t r;
    int b;
    int n;
    int hit;
    r        = '0;
    r.status = ST_NONE;
    b        = int'(c.box) % NUM_BOXES;
    n        = int'(mirror_fill[b]);
    hit      = -1;
    case (c.opcode)
      OP_ENQ: begin
        if (n >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          mirror_handle[b][n] = HANDLE_BITS'(c.msg_handle);
          mirror_sender[b][n] = c.msg_sender;
          mirror_fill[b]      = n + 1;
          r.status            = ST_DONE;
        end
      end
      OP_DEQ_ANY: begin
        if (n > 0) take_entry(b, 0, r);
      end
      OP_DEQ_FROM: begin
        for (int i = 0; i < n; i++) begin
          if (hit < 0 && mirror_sender[b][i] == c.want_sender) hit = i;
        end
        if (hit >= 0) take_entry(b, hit, r);
      end
      default: ;
    endcase
    r.now_empty = (mirror_fill[b] == 0);
    return r;
  endfunction

  function automatic dir_row_t dir_row(logic [OP_W-1:0] op, int box, int snd, int hdl,
                                       int want, int reps, bit typed,
                                       logic [STAT_W-1:0] st, int gh, int gs, bit emp);
    dir_row_t d;
    d.cmd   = '{opcode: op, box: BOXIN_W'(box), msg_sender: SND_W'(snd),
                msg_handle: HDLIN_W'(hdl), want_sender: SND_W'(want)};
    d.reps  = reps;
    d.typed = typed;
    d.res   = '{status: st, got_handle: HDLIN_W'(gh), got_sender: SND_W'(gs),
                now_empty: emp};
    return d;
  endfunction

  // Offers one command beat, waits for it to be taken and records what must come back.
  task automatic issue(mail_cmd_t c, bit typed, mail_res_t typed_res);
    mail_res_t predicted;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_opcode      <= c.opcode;
    in_box         <= c.box;
    in_msg_sender  <= c.msg_sender;
    in_msg_handle  <= c.msg_handle;
    in_want_sender <= c.want_sender;
    do @(posedge clk); while (in_stall);
    predicted = mailbox_step(c);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin : stimulus
    mail_cmd_t c;
    int counted;
    int phase_left;
    int mode;
    int hot_box;
    int enq_pct;
    int r;
    int b;
    for (int i = 0; i < NUM_BOXES; i++) mirror_fill[i] = 0;

    // Empty boxes, the unused opcode, a missed and a hit selective receive,
    // then one box filled to the brim and an enqueue refused as full.
    directed_rows[0]  = dir_row(OP_DEQ_ANY,  0, 0, 0,      0, 1,  1, ST_NONE, 0, 0, 1);
    directed_rows[1]  = dir_row(OP_DEQ_FROM, 7, 7, 16'hFFFF, 7, 1, 1, ST_NONE, 0, 0, 1);
    directed_rows[2]  = dir_row(OP_UNUSED,   5, 7, 16'hFFFF, 7, 1, 1, ST_NONE, 0, 0, 1);
    directed_rows[3]  = dir_row(OP_ENQ,      0, 0, 0,      0, 1,  1, ST_DONE, 0, 0, 0);
    directed_rows[4]  = dir_row(OP_ENQ,      0, 7, 16'hFFFF, 0, 1, 1, ST_DONE, 0, 0, 0);
    directed_rows[5]  = dir_row(OP_ENQ,      0, 3, 16'h1234, 0, 1, 0, ST_DONE, 0, 0, 0);
    directed_rows[6]  = dir_row(OP_DEQ_FROM, 0, 0, 0,      5, 1,  1, ST_NONE, 0, 0, 0);
    directed_rows[7]  = dir_row(OP_DEQ_FROM, 0, 0, 0,      7, 1,  1, ST_DONE, 16'hFFFF, 7, 0);
    directed_rows[8]  = dir_row(OP_DEQ_ANY,  0, 0, 0,      0, 1,  0, ST_DONE, 0, 0, 0);
    directed_rows[9]  = dir_row(OP_DEQ_ANY,  0, 0, 0,      0, 1,  0, ST_DONE, 0, 0, 0);
    directed_rows[10] = dir_row(OP_ENQ,      7, 0, 16'h8000, 0, DEPTH, 0, ST_DONE, 0, 0, 0);
    directed_rows[11] = dir_row(OP_ENQ,      7, 7, 16'hFFFF, 0, 1, 1, ST_FULL, 0, 0, 0);
    directed_rows[12] = dir_row(OP_DEQ_FROM, 7, 0, 0,      5, 1,  0, ST_DONE, 0, 0, 0);
    directed_rows[13] = dir_row(OP_DEQ_ANY,  7, 0, 0,      0, 1,  0, ST_DONE, 0, 0, 0);

    while (!rst_n) @(posedge clk);

    for (int i = 0; i < N_ROWS; i++) begin
      for (int k = 0; k < directed_rows[i].reps; k++) begin
        c            = directed_rows[i].cmd;
        c.msg_handle = c.msg_handle + HDLIN_W'(k);
        c.msg_sender = c.msg_sender + SND_W'(k);
        issue(c, directed_rows[i].typed, directed_rows[i].res);
      end
    end

    // Phases lean on one box at a time so that boxes fill up, run dry and
    // hold long runs for the selective receive to search through.
    counted    = 0;
    phase_left = 0;
    mode       = 0;
    hot_box    = 0;
    while (counted < N_RANDOM) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 60);
        mode       = $urandom_range(0, 2);
        hot_box    = $urandom_range(0, NUM_BOXES - 1);
      end
      enq_pct = (mode == 0) ? 70 : (mode == 1) ? 25 : 45;
      b = ($urandom_range(0, 99) < 80) ? hot_box : $urandom_range(0, NUM_BOXES - 1);
      c.box         = BOXIN_W'(b);
      c.msg_sender  = SND_W'($urandom_range(0, 7));
      c.msg_handle  = HDLIN_W'($urandom);
      c.want_sender = SND_W'($urandom_range(0, 7));
      r = $urandom_range(0, 99);
      if (r < 4)
        c.opcode = OP_UNUSED;
      else if (r < 4 + enq_pct)
        c.opcode = OP_ENQ;
      else if (r < 4 + enq_pct + (96 - enq_pct) / 3)
        c.opcode = OP_DEQ_ANY;
      else
        c.opcode = OP_DEQ_FROM;
      // Mostly ask for a sender that really is waiting in the box.
      if (c.opcode == OP_DEQ_FROM && mirror_fill[b] > 0 && $urandom_range(0, 3) != 0)
        c.want_sender = mirror_sender[b][$urandom_range(0, mirror_fill[b] - 1)];
      issue(c, 1'b0, '0);
      if (c.opcode != OP_UNUSED) begin
        counted++;
        phase_left--;
        if (counted == N_RANDOM / 4) hold_request = 1'b1;
        if (counted == N_RANDOM / 2) drain_results();
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // The receiver stalls in segments of random length, each with its own
  // stall rate, and once holds off for a long stretch so the block backs up.
  initial begin : receiver
    int seg_left;
    int stall_pct;
    seg_left  = 0;
    stall_pct = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(10, 80);
          case ($urandom_range(0, 3))
            0:       stall_pct = 0;
            1:       stall_pct = 25;
            2:       stall_pct = 50;
            default: stall_pct = 80;
          endcase
        end
        seg_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  function automatic void check_field(string what, logic [31:0] expv, logic [31:0] actv);
    if (expv !== actv) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, expv, actv);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    mail_res_t want_res;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected: expected none, actual %0h",
                 $time, {out_status, out_got_handle, out_got_sender, out_now_empty});
        mismatches++;
      end else begin
        want_res = pending_results.pop_front();
        check_field("status",     32'(want_res.status),     32'(out_status));
        check_field("got_handle", 32'(want_res.got_handle), 32'(out_got_handle));
        check_field("got_sender", 32'(want_res.got_sender), 32'(out_got_sender));
        check_field("now_empty",  32'(want_res.now_empty),  32'(out_now_empty));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

[sim.f]
hw/rtl/mqsr_pkg.sv
hw/rtl/mailbox_queue_selective_receive.sv
sim/tb_mailbox_queue_selective_receive.sv
